@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, quiet while reset is held
`define MPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal must hold a value at or below a limit whenever out of reset
`define MPA_ASSERT_BELOW(label, sig, lim, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ((sig) <= (lim))) else $error(msg);

`endif

@@ hw/rtl/mpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mpa_pkg;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_DEADLINE = 3'd1;
  localparam logic [2:0] OP_PULSE    = 3'd2;
  localparam logic [2:0] OP_FIRE     = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  localparam logic [1:0] KIND_DEADLINE = 2'd0;
  localparam logic [1:0] KIND_RECORD   = 2'd1;
  localparam logic [1:0] KIND_READOUT  = 2'd2;

  localparam logic [2:0] CFG_MEASURING = 3'd0;
  localparam logic [2:0] CFG_COUNT     = 3'd1;
  localparam logic [2:0] CFG_SKIP      = 3'd2;
  localparam logic [2:0] CFG_GATE      = 3'd3;
  localparam logic [2:0] CFG_REPORT    = 3'd4;

  localparam int CUR_W       = 5;
  localparam int DIVIDEND_W  = 32;
  localparam int MOD_BITS    = 4;
  localparam int MOD_STEPS   = DIVIDEND_W / MOD_BITS;
  localparam logic [16:0] FULL_SCALE = 17'd32768;

  typedef struct packed {
    logic [63:0] offset;
    logic [2:0]  groups;
    logic [15:0] masks;
  } point_t;

  typedef struct packed {
    logic [63:0] sq;
    logic [31:0] sum;
    logic [31:0] cnt;
  } line_t;

  typedef struct packed {
    logic [63:0]        acc_sum_squares;
    logic signed [31:0] acc_sum;
    logic [31:0]        acc_count;
    logic signed [15:0] raw_ch1_current;
    logic signed [15:0] raw_ch1_voltage;
    logic signed [15:0] raw_ch0_current;
    logic signed [15:0] raw_ch0_voltage;
    logic [3:0]         valid_lines;
    logic [3:0]         point_out;
    logic [31:0]        count_or_pulse;
    logic [63:0]        time_out;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/mpa_point_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mpa_point_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire mpa_pkg::point_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output mpa_pkg::point_t      rdata
);

  mpa_pkg::point_t mem [DEPTH];
  mpa_pkg::point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/mpa_line_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mpa_line_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire mpa_pkg::line_t                    wdata,
  input  wire logic [AW-1:0]                     raddr,
  input  wire logic                              clr,
  input  wire logic [mpa_pkg::CUR_W-1:0]         clr_points,
  output mpa_pkg::line_t                         rdata
);

  mpa_pkg::line_t mem [DEPTH];
  mpa_pkg::line_t rdata_r;
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic rvalid_r;

  // entries not yet written since reset, or since a clear of their point, read as zero
  always_comb begin
    valid_nxt = valid_r;
    if (clr) begin
      for (int a = 0; a < DEPTH; a++) begin
        if ((a / 4) < int'(clr_points)) begin
          valid_nxt[a] = 1'b0;
        end
      end
    end
    if (we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r  <= mem[raddr];
    rvalid_r <= valid_r[raddr];
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule
`default_nettype wire

@@ hw/rtl/mpa_mod_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mpa_mod_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [mpa_pkg::DIVIDEND_W-1:0]     dividend,
  input  wire logic [2:0]                         divisor,
  output logic                                    done,
  output logic [1:0]                              rem
);

  localparam int CNT_W = $clog2(mpa_pkg::MOD_STEPS);

  logic [mpa_pkg::DIVIDEND_W-1:0] shift_r, shift_nxt;
  logic [2:0] div_r;
  logic [2:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r, done_r;

  // restoring remainder, MOD_BITS dividend bits per cycle
  always_comb begin
    logic [3:0] t;
    rem_nxt   = rem_r;
    shift_nxt = shift_r;
    for (int b = 0; b < mpa_pkg::MOD_BITS; b++) begin
      t = {rem_nxt, shift_nxt[mpa_pkg::DIVIDEND_W-1]};
      shift_nxt = {shift_nxt[mpa_pkg::DIVIDEND_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_nxt = t[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(mpa_pkg::MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      div_r   <= divisor;
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[1:0];

endmodule
`default_nettype wire

@@ hw/rtl/measurement_point_accumulator_top.sv @@
// measurement point accumulator
// in channel: one command per transfer, operation in in_tuser, arguments in in_tdata
// cfg channel: register writes by index, always ready; the user writes only while the
// block is idle; the block itself leaves this unenforced
// out channel: at most one result per command, kind in out_tuser
// steps per command, one state each (load, pulse done, clear: the idle state alone):
//   readout: one read of the line memory, then into the output register
//   deadline: serial skip scan past the skipped points, then the offset add, then
//     the output register; no add when no point is left, no scan with measuring off
//   fire: the idle state alone when gated or past the plan; otherwise a point read,
//     the serial modulo unit (4 dividend bits a cycle) when the point has more than
//     one group, the three-step line update (read, square, write back) through the
//     shared accumulator datapath per line read and a check per line not read, then
//     the output register when reporting
// in_tready is high only while the sequencer is idle
// a result sits in the output register until taken; the next command is accepted
// meanwhile, and its own result waits in the sequencer until that register frees up
// reset: control registers cleared, all accumulators read as zero, cursor and skip
// count zero; the point table holds nothing defined until loaded
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module measurement_point_accumulator_top #(
  parameter int MAX_POINTS = 16,
  parameter int MAX_GROUPS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // point_index, line_select, cycle_value, group_count, group_masks, pulse_number,
  // envelope_level, sample_ch0_voltage, sample_ch0_current, sample_ch1_voltage,
  // sample_ch1_current
  input  wire logic [207:0] in_tdata,
  // operation
  input  wire logic [2:0]   in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // time_out, count_or_pulse, point_out, valid_lines, raw_ch0_voltage,
  // raw_ch0_current, raw_ch1_voltage, raw_ch1_current, acc_count, acc_sum,
  // acc_sum_squares
  output logic [295:0]      out_tdata,
  // result_kind
  output logic [1:0]        out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int PIW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int LAW    = PIW + 2;
  localparam int NLINES = MAX_POINTS * 4;
  localparam int CW     = mpa_pkg::CUR_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DL_SCAN = 4'd1;
  localparam logic [3:0] S_DL_ADD  = 4'd2;
  localparam logic [3:0] S_F_RD    = 4'd3;
  localparam logic [3:0] S_F_MOD   = 4'd4;
  localparam logic [3:0] S_L_RD    = 4'd5;
  localparam logic [3:0] S_L_MUL   = 4'd6;
  localparam logic [3:0] S_L_WR    = 4'd7;
  localparam logic [3:0] S_RO_OUT  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  // input fields
  logic [3:0]  in_point;
  logic [1:0]  in_line;
  logic [63:0] in_cycle;
  logic [2:0]  in_groups;
  logic [15:0] in_masks;
  logic [31:0] in_pulse;
  logic [15:0] in_env;
  logic [63:0] in_samples;

  assign in_point   = in_tdata[3:0];
  assign in_line    = in_tdata[5:4];
  assign in_cycle   = in_tdata[69:6];
  assign in_groups  = in_tdata[72:70];
  assign in_masks   = in_tdata[88:73];
  assign in_pulse   = in_tdata[120:89];
  assign in_env     = in_tdata[136:121];
  assign in_samples = in_tdata[200:137];

  // configuration
  logic        measuring_r;
  logic [4:0]  count_r;
  logic [15:0] skip_r;
  logic        gate_r;
  logic [1:0]  report_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measuring_r <= 1'b0;
      count_r     <= '0;
      skip_r      <= '0;
      gate_r      <= 1'b0;
      report_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpa_pkg::CFG_MEASURING: measuring_r <= cfg_data[0];
        mpa_pkg::CFG_COUNT:     count_r     <= cfg_data[4:0];
        mpa_pkg::CFG_SKIP:      skip_r      <= cfg_data;
        mpa_pkg::CFG_GATE:      gate_r      <= cfg_data[0];
        mpa_pkg::CFG_REPORT:    report_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // active points, clamped to the table size
  logic [CW-1:0] n_points;
  assign n_points = (count_r > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : count_r;

  // sequencer registers
  logic [3:0]      state_r, state_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [31:0]     skips_r, skips_nxt;
  logic            out_valid_r, out_valid_nxt;
  mpa_pkg::res_t   out_r, out_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  mpa_pkg::res_t   res_r, res_nxt;
  logic [1:0]      kind_r, kind_nxt;

  // item working registers
  logic [63:0]     cycle_r, cycle_nxt;
  logic [31:0]     pulse_r, pulse_nxt;
  logic [63:0]     samples_r, samples_nxt;
  logic [PIW-1:0]  idx_r, idx_nxt;
  logic [15:0]     masks_r, masks_nxt;
  logic [1:0]      grp_r, grp_nxt;
  logic [1:0]      line_r, line_nxt;
  logic            ro_ok_r, ro_ok_nxt;
  logic [31:0]     sq_r, sq_nxt;
  mpa_pkg::line_t  acc_r, acc_nxt;

  // shared units
  mpa_pkg::point_t pt_wdata, pt_rdata;
  logic            pt_we;
  mpa_pkg::line_t  ln_wdata, ln_rdata;
  logic            ln_we, ln_clr;
  logic [LAW-1:0]  ln_waddr, ln_raddr;
  logic            mod_start, mod_done;
  logic [1:0]      mod_rem;

  mpa_point_table #(.DEPTH(MAX_POINTS), .AW(PIW)) u_points (
    .clk   (clk),
    .we    (pt_we),
    .waddr (in_point[PIW-1:0]),
    .wdata (pt_wdata),
    .raddr (cursor_r[PIW-1:0]),
    .rdata (pt_rdata)
  );

  mpa_line_store #(.DEPTH(NLINES), .AW(LAW)) u_lines (
    .clk        (clk),
    .rst_n      (rst_n),
    .we         (ln_we),
    .waddr      (ln_waddr),
    .wdata      (ln_wdata),
    .raddr      (ln_raddr),
    .clr        (ln_clr),
    .clr_points (n_points),
    .rdata      (ln_rdata)
  );

  mpa_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (pulse_r),
    .divisor  (pt_rdata.groups),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  logic             in_ok;
  logic             point_ok;
  logic [3:0]       rmask;
  logic signed [15:0] cur_sample;
  logic [15:0]      cur_mag;

  assign in_tready = (state_r == S_IDLE);
  assign in_ok     = in_tvalid && in_tready;
  assign point_ok  = ({1'b0, in_point} < CW'(MAX_POINTS));
  assign rmask     = masks_r[{grp_r, 2'b00} +: 4];
  assign cur_sample = samples_r[{line_r, 4'b0000} +: 16];
  assign cur_mag    = cur_sample[15] ? 16'(-cur_sample) : cur_sample;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    skips_nxt     = skips_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    out_kind_nxt  = out_kind_r;
    res_nxt       = res_r;
    kind_nxt      = kind_r;
    cycle_nxt     = cycle_r;
    pulse_nxt     = pulse_r;
    samples_nxt   = samples_r;
    idx_nxt       = idx_r;
    masks_nxt     = masks_r;
    grp_nxt       = grp_r;
    line_nxt      = line_r;
    ro_ok_nxt     = ro_ok_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    pt_we         = 1'b0;
    pt_wdata.offset = in_cycle;
    pt_wdata.groups = (in_groups > 3'(MAX_GROUPS)) ? 3'(MAX_GROUPS) : in_groups;
    pt_wdata.masks  = in_masks;
    ln_we         = 1'b0;
    ln_clr        = 1'b0;
    ln_waddr      = {idx_r, line_r};
    ln_wdata.cnt  = acc_r.cnt + 32'd1;
    ln_wdata.sum  = acc_r.sum + 32'(cur_sample);
    ln_wdata.sq   = acc_r.sq + {32'd0, sq_r};
    ln_raddr      = {idx_r, line_r};
    mod_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        ln_raddr  = {in_point[PIW-1:0], in_line};
        cycle_nxt = in_cycle;
        pulse_nxt = in_pulse;
        samples_nxt = in_samples;
        if (in_ok) begin
          res_nxt = '0;
          case (in_tuser)
            mpa_pkg::OP_LOAD: begin
              pt_we = point_ok;
            end
            mpa_pkg::OP_DEADLINE: begin
              kind_nxt = mpa_pkg::KIND_DEADLINE;
              res_nxt.time_out = '1;
              state_nxt = measuring_r ? S_DL_SCAN : S_EMIT;
            end
            mpa_pkg::OP_PULSE: begin
              cursor_nxt = '0;
            end
            mpa_pkg::OP_FIRE: begin
              if (cursor_r < n_points) begin
                cursor_nxt = cursor_r + 1'b1;
                idx_nxt    = cursor_r[PIW-1:0];
                if (gate_r && ({1'b0, in_env} < mpa_pkg::FULL_SCALE)) begin
                  skips_nxt = skips_r + 32'd1;
                end else begin
                  state_nxt = S_F_RD;
                end
              end
            end
            mpa_pkg::OP_READ: begin
              kind_nxt = mpa_pkg::KIND_READOUT;
              res_nxt.count_or_pulse = skips_r;
              res_nxt.point_out      = in_point;
              ro_ok_nxt = point_ok;
              state_nxt = S_RO_OUT;
            end
            mpa_pkg::OP_CLEAR: begin
              ln_clr     = 1'b1;
              cursor_nxt = '0;
              skips_nxt  = '0;
            end
            default: ;
          endcase
        end
      end

      // skip scan, one point per cycle
      S_DL_SCAN: begin
        if (cursor_r < n_points) begin
          if (skip_r[cursor_r[3:0]]) begin
            cursor_nxt = cursor_r + 1'b1;
          end else begin
            state_nxt = S_DL_ADD;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_DL_ADD: begin
        res_nxt.time_out = cycle_r + pt_rdata.offset;
        state_nxt = S_EMIT;
      end

      S_F_RD: begin
        masks_nxt = pt_rdata.masks;
        line_nxt  = 2'd0;
        if (pt_rdata.groups > 3'd1) begin
          mod_start = 1'b1;
          state_nxt = S_F_MOD;
        end else begin
          grp_nxt   = 2'd0;
          state_nxt = S_L_RD;
        end
      end

      S_F_MOD: begin
        if (mod_done) begin
          grp_nxt   = mod_rem;
          state_nxt = S_L_RD;
        end
      end

      S_L_RD: begin
        if (rmask[line_r]) begin
          state_nxt = S_L_MUL;
        end else if (line_r == 2'd3) begin
          state_nxt = S_EMIT;
        end else begin
          line_nxt = line_r + 2'd1;
        end
        if (!rmask[line_r] && line_r == 2'd3) begin
          kind_nxt = mpa_pkg::KIND_RECORD;
          res_nxt.time_out       = cycle_r;
          res_nxt.count_or_pulse = pulse_r;
          res_nxt.point_out      = 4'(idx_r);
          if (report_r == 2'd0) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_L_MUL: begin
        acc_nxt   = ln_rdata;
        sq_nxt    = {16'd0, cur_mag} * {16'd0, cur_mag};
        state_nxt = S_L_WR;
      end

      S_L_WR: begin
        ln_we = 1'b1;
        res_nxt.valid_lines[line_r] = 1'b1;
        case (line_r)
          2'd0: res_nxt.raw_ch0_voltage = cur_sample;
          2'd1: res_nxt.raw_ch0_current = cur_sample;
          2'd2: res_nxt.raw_ch1_voltage = cur_sample;
          default: res_nxt.raw_ch1_current = cur_sample;
        endcase
        if (line_r == 2'd3) begin
          kind_nxt = mpa_pkg::KIND_RECORD;
          res_nxt.time_out       = cycle_r;
          res_nxt.count_or_pulse = pulse_r;
          res_nxt.point_out      = 4'(idx_r);
          state_nxt = (report_r == 2'd0) ? S_IDLE : S_EMIT;
        end else begin
          line_nxt  = line_r + 2'd1;
          state_nxt = S_L_RD;
        end
      end

      S_RO_OUT: begin
        if (ro_ok_r) begin
          res_nxt.acc_count       = ln_rdata.cnt;
          res_nxt.acc_sum         = ln_rdata.sum;
          res_nxt.acc_sum_squares = ln_rdata.sq;
        end
        state_nxt = S_EMIT;
      end

      // wait for the output register to free up
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          out_kind_nxt  = kind_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      skips_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      skips_r     <= skips_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    out_kind_r <= out_kind_nxt;
    res_r      <= res_nxt;
    kind_r     <= kind_nxt;
    cycle_r    <= cycle_nxt;
    pulse_r    <= pulse_nxt;
    samples_r  <= samples_nxt;
    idx_r      <= idx_nxt;
    masks_r    <= masks_nxt;
    grp_r      <= grp_nxt;
    line_r     <= line_nxt;
    ro_ok_r    <= ro_ok_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
  end

  assign out_tdata  = out_r;
  assign out_tuser  = out_kind_r;
  assign out_tvalid = out_valid_r;

  `MPA_ASSERT_BELOW(a_cursor_range, cursor_r, CW'(MAX_POINTS), "cursor beyond table")
  `MPA_ASSERT(a_emit_holds, (state_r == S_EMIT && out_valid_r && !out_tready) |=> (state_r == S_EMIT), "result lost while output stalled")
  `MPA_ASSERT(a_wr_after_mul, (state_r == S_L_WR) |-> ($past(state_r) == S_L_MUL), "line write without square step")
  `MPA_ASSERT(a_mod_in_wait, mod_done |-> (state_r == S_F_MOD), "modulo finished outside its wait state")

endmodule
`default_nettype wire

@@ tb/sv/measurement_point_accumulator_top_test.sv @@
`timescale 1ns / 1ps
module measurement_point_accumulator_top_test;

  // command arguments, packed as in in_tdata from the msb down
  typedef struct packed {
    logic signed [15:0] s1c;
    logic signed [15:0] s1v;
    logic signed [15:0] s0c;
    logic signed [15:0] s0v;
    logic [15:0]        env;
    logic [31:0]        pulse;
    logic [15:0]        masks;
    logic [2:0]         groups;
    logic [63:0]        cyc;
    logic [1:0]         line;
    logic [3:0]         point;
  } cmd_t;

  typedef struct {
    logic [1:0]    kind;
    mpa_pkg::res_t res;
  } outcome_t;

  typedef struct {
    int         phase;
    logic [2:0] op;
    cmd_t       cmd;
    bit         typed;
    logic [63:0] want_time;
  } row_t;

  localparam int NPTS = 16;
  localparam logic [63:0] NONE = 64'hffff_ffff_ffff_ffff;
  // operation codes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic         clk = 0;
  logic         rst_n = 0;
  logic [207:0] in_tdata = '0;
  logic [2:0]   in_tuser = mpa_pkg::OP_LOAD;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [295:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = mpa_pkg::CFG_MEASURING;
  logic [15:0]  cfg_data = '0;

  measurement_point_accumulator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow of the plan, the point table and the line accumulators
  logic [63:0] plan_offset [NPTS];
  logic [2:0]  plan_groups [NPTS];
  logic [15:0] plan_masks [NPTS];
  logic [31:0] line_cnt [NPTS*4];
  logic [31:0] line_sum [NPTS*4];
  logic [63:0] line_sq [NPTS*4];
  logic [4:0]  cursor;
  logic [31:0] env_skips;
  logic        r_measuring;
  logic [4:0]  r_count;
  logic [15:0] r_skip;
  logic        r_gate;
  logic [1:0]  r_report;

  outcome_t pending_results[$];
  row_t     rows[$];
  int       fails = 0;
  int       mismatches = 0;
  int       cycles = 0;
  logic [31:0] pulse_seq = 0;

  // cycle limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("measurement_point_accumulator_top_test failed");
      $finish;
    end
  end

  // short gaps mostly, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1;
      stall_left <= pick_gap();
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    mpa_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = mpa_pkg::res_t'(out_tdata);
      if (pending_results.size() == 0) begin
        fails++;
        if (mismatches < 10)
          $display("unexpected result kind %0d data %h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (e.kind !== out_tuser || e.res.time_out !== got.time_out ||
            e.res.count_or_pulse !== got.count_or_pulse ||
            e.res.point_out !== got.point_out || e.res.valid_lines !== got.valid_lines ||
            e.res.raw_ch0_voltage !== got.raw_ch0_voltage ||
            e.res.raw_ch0_current !== got.raw_ch0_current ||
            e.res.raw_ch1_voltage !== got.raw_ch1_voltage ||
            e.res.raw_ch1_current !== got.raw_ch1_current ||
            e.res.acc_count !== got.acc_count || e.res.acc_sum !== got.acc_sum ||
            e.res.acc_sum_squares !== got.acc_sum_squares) begin
          fails++;
          if (mismatches < 10)
            $display("mismatch: kind exp %0d got %0d\n  exp %h\n  got %h",
                     e.kind, out_tuser, e.res, got);
          mismatches++;
        end
      end
    end
  end

  // effect of one accepted command on the shadow state, queues its result
  task automatic apply_command(input logic [2:0] op, input cmd_t c);
    outcome_t o;
    logic [4:0] n;
    logic [1:0] g;
    logic [3:0] rmask;
    logic signed [15:0] s [4];
    logic [31:0] mag;
    int a;
    o.kind = mpa_pkg::KIND_DEADLINE;
    o.res = '0;
    n = (r_count > NPTS) ? 5'(NPTS) : r_count;
    s[0] = c.s0v; s[1] = c.s0c; s[2] = c.s1v; s[3] = c.s1c;
    case (op)
      mpa_pkg::OP_LOAD: begin
        plan_offset[c.point] = c.cyc;
        plan_groups[c.point] = (c.groups > 4) ? 3'd4 : c.groups;
        plan_masks[c.point] = c.masks;
      end
      mpa_pkg::OP_DEADLINE: begin
        o.res.time_out = NONE;
        if (r_measuring) begin
          while (cursor < n && r_skip[cursor[3:0]]) cursor++;
          if (cursor < n) o.res.time_out = c.cyc + plan_offset[cursor[3:0]];
        end
        pending_results.push_back(o);
      end
      mpa_pkg::OP_PULSE: cursor = 0;
      mpa_pkg::OP_FIRE: begin
        if (cursor < n) begin
          a = cursor;
          cursor++;
          if (r_gate && c.env < 16'd32768) begin
            env_skips++;
          end else begin
            g = (plan_groups[a] > 1) ? 2'(c.pulse % plan_groups[a]) : 2'd0;
            rmask = 4'(plan_masks[a] >> (4 * g));
            for (int l = 0; l < 4; l++) begin
              if (rmask[l]) begin
                mag = (s[l] < 0) ? 32'(-32'(s[l])) : 32'(s[l]);
                line_cnt[a*4+l]++;
                line_sum[a*4+l] += 32'(s[l]);
                line_sq[a*4+l] += 64'(mag) * 64'(mag);
              end
            end
            if (r_report != 0) begin
              o.kind = mpa_pkg::KIND_RECORD;
              o.res.time_out = c.cyc;
              o.res.count_or_pulse = c.pulse;
              o.res.point_out = 4'(a);
              o.res.valid_lines = rmask;
              o.res.raw_ch0_voltage = rmask[0] ? s[0] : '0;
              o.res.raw_ch0_current = rmask[1] ? s[1] : '0;
              o.res.raw_ch1_voltage = rmask[2] ? s[2] : '0;
              o.res.raw_ch1_current = rmask[3] ? s[3] : '0;
              pending_results.push_back(o);
            end
          end
        end
      end
      mpa_pkg::OP_READ: begin
        a = c.point * 4 + c.line;
        o.kind = mpa_pkg::KIND_READOUT;
        o.res.count_or_pulse = env_skips;
        o.res.point_out = c.point;
        o.res.acc_count = line_cnt[a];
        o.res.acc_sum = line_sum[a];
        o.res.acc_sum_squares = line_sq[a];
        pending_results.push_back(o);
      end
      mpa_pkg::OP_CLEAR: begin
        for (int i = 0; i < n * 4; i++) begin
          line_cnt[i] = 0; line_sum[i] = 0; line_sq[i] = 0;
        end
        cursor = 0;
        env_skips = 0;
      end
      default: ;
    endcase
  endtask

  // one command transfer; valid stays up for back-to-back commands
  task automatic send(input logic [2:0] op, input cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tuser <= op;
    in_tdata <= {7'b0, c};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    apply_command(op, c);
  endtask

  // valid stays up across back-to-back writes; the caller drops it after the last
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mpa_pkg::CFG_MEASURING: r_measuring = val[0];
      mpa_pkg::CFG_COUNT:     r_count = val[4:0];
      mpa_pkg::CFG_SKIP:      r_skip = val;
      mpa_pkg::CFG_GATE:      r_gate = val[0];
      mpa_pkg::CFG_REPORT:    r_report = val[1:0];
      default: ;
    endcase
  endtask

  // drain all results, then let a result-less fire finish its line updates
  task automatic settle();
    in_tvalid <= 0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_plan(input logic m, input logic [4:0] cnt, input logic [15:0] sk,
                          input logic gt, input logic [1:0] rp);
    settle();
    write_reg(mpa_pkg::CFG_MEASURING, 16'(m));
    write_reg(mpa_pkg::CFG_COUNT, 16'(cnt));
    write_reg(mpa_pkg::CFG_SKIP, sk);
    write_reg(mpa_pkg::CFG_GATE, 16'(gt));
    write_reg(mpa_pkg::CFG_REPORT, 16'(rp));
    cfg_valid <= 0;
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c.point = 4'($urandom);
    c.line = 2'($urandom);
    c.cyc = {$urandom, $urandom};
    c.groups = 3'($urandom);
    c.masks = 16'($urandom);
    c.pulse = ($urandom_range(0, 9) == 0) ? $urandom : pulse_seq;
    r = $urandom_range(0, 9);
    c.env = (r < 4) ? 16'($urandom_range(0, 32767)) :
            (r < 7) ? 16'd32768 : 16'($urandom_range(32768, 65535));
    c.s0v = 16'($urandom); c.s0c = 16'($urandom);
    c.s1v = 16'($urandom); c.s1c = 16'($urandom);
    return c;
  endfunction

  task automatic add_row(input int ph, input logic [2:0] op, input cmd_t c,
                         input bit typed, input logic [63:0] want);
    row_t r;
    r.phase = ph; r.op = op; r.cmd = c; r.typed = typed; r.want_time = want;
    rows.push_back(r);
  endtask

  initial begin
    cmd_t c;
    int ph;
    int r;
    logic [2:0] op;
    for (int i = 0; i < NPTS*4; i++) begin
      line_cnt[i] = 0; line_sum[i] = 0; line_sq[i] = 0;
    end
    for (int i = 0; i < NPTS; i++) begin
      plan_offset[i] = 0; plan_groups[i] = 0; plan_masks[i] = 0;
    end
    cursor = 0; env_skips = 0;
    r_measuring = 0; r_count = 0; r_skip = 0; r_gate = 0; r_report = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // fill the whole point table first, group counts 0..7 and extreme offsets
    for (int p = 0; p < NPTS; p++) begin
      c = rand_cmd();
      c.point = 4'(p);
      c.groups = 3'(p);
      c.cyc = (p == 1) ? NONE : (p == 0) ? 64'd0 : c.cyc;
      c.masks = (p == 0) ? 16'hffff : (p == 2) ? 16'h0000 : c.masks;
      send(mpa_pkg::OP_LOAD, c);
    end

    // directed rows; typed expectations where obvious
    c = rand_cmd();
    add_row(0, mpa_pkg::OP_DEADLINE, c, 1, NONE);        // measuring off
    add_row(0, mpa_pkg::OP_FIRE, c, 0, 0);               // empty plan, nothing
    c.point = 0; c.line = 0;
    add_row(0, mpa_pkg::OP_READ, c, 1, 64'd0);           // accumulators after reset
    c = rand_cmd(); c.cyc = NONE;
    add_row(1, mpa_pkg::OP_DEADLINE, c, 0, 0);           // skips point 0, wraps offset
    c = rand_cmd(); c.pulse = 32'hffff_ffff; c.cyc = NONE;
    c.s0v = -16'sd32768; c.s0c = 16'sd32767; c.s1v = -16'sd1; c.s1c = 16'sd0;
    add_row(1, mpa_pkg::OP_FIRE, c, 0, 0);
    c.s0v = 16'sd32767; c.s0c = -16'sd32768; c.pulse = 0; c.cyc = 0;
    add_row(1, mpa_pkg::OP_FIRE, c, 0, 0);
    add_row(1, mpa_pkg::OP_FIRE, c, 0, 0);
    c.point = 1; c.line = 0;
    add_row(1, mpa_pkg::OP_READ, c, 0, 0);
    add_row(1, mpa_pkg::OP_PULSE, c, 0, 0);
    add_row(1, OP_SPARE_LO, c, 0, 0);                    // unknown operations ignored
    add_row(1, OP_SPARE_HI, c, 0, 0);
    add_row(1, mpa_pkg::OP_CLEAR, c, 0, 0);
    add_row(1, mpa_pkg::OP_READ, c, 0, 0);
    c = rand_cmd(); c.env = 16'd32767;
    add_row(2, mpa_pkg::OP_FIRE, c, 0, 0);               // gated, counted as skipped
    c.env = 16'd32768;
    add_row(2, mpa_pkg::OP_FIRE, c, 0, 0);               // full scale passes the gate
    c.env = 16'hffff;
    add_row(2, mpa_pkg::OP_FIRE, c, 0, 0);               // past the plan
    add_row(2, mpa_pkg::OP_DEADLINE, c, 1, NONE);        // every point masked
    c.point = 15; c.line = 3;
    add_row(2, mpa_pkg::OP_READ, c, 0, 0);

    ph = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != ph) begin
        ph = rows[i].phase;
        if (ph == 1) set_plan(1, 5'd31, 16'h8001, 0, 2'd3);
        else set_plan(1, 5'd2, 16'hffff, 1, 2'd0);
      end
      send(rows[i].op, rows[i].cmd);
      if (rows[i].typed &&
          pending_results[pending_results.size()-1].res.time_out !== rows[i].want_time) begin
        fails++;
        $display("row %0d: predicted time %h, table says %h", i,
                 pending_results[pending_results.size()-1].res.time_out, rows[i].want_time);
      end
    end

    // random phases, each with its own plan settings
    for (int k = 0; k < 10; k++) begin
      if (k == 0) set_plan(1, 5'd16, 16'h0000, 0, 2'd1);
      else if (k == 9) set_plan(0, 5'd0, 16'hffff, 1, 2'd3);
      else set_plan($urandom_range(0, 9) != 0,
                    ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(1, 5)),
                    16'($urandom & $urandom), 1'($urandom), 2'($urandom));
      for (int j = 0; j < 125; j++) begin
        // occasional hold-off until the block has nothing outstanding
        if (j == 60 && k % 3 == 0) settle();
        c = rand_cmd();
        r = $urandom_range(0, 99);
        if (r < 8) begin
          op = mpa_pkg::OP_PULSE;
          pulse_seq++;
        end
        else if (r < 32) op = mpa_pkg::OP_DEADLINE;
        else if (r < 74) op = mpa_pkg::OP_FIRE;
        else if (r < 87) op = mpa_pkg::OP_READ;
        else if (r < 93) op = mpa_pkg::OP_LOAD;
        else if (r < 96) op = mpa_pkg::OP_CLEAR;
        else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        send(op, c);
      end
    end

    settle();
    if (fails == 0)
      $display("measurement_point_accumulator_top_test passed");
    else
      $display("measurement_point_accumulator_top_test failed");
    $finish;
  end

endmodule
